/* rtl/tlbpt_pkg.sv */
`timescale 1ns / 1ps
package tlbpt_pkg;
   localparam int PAGE_COUNT_DEF  = 16;
   localparam int FRAME_COUNT_DEF = 8;
   localparam int TLB_DEPTH_DEF   = 4;
   localparam int OFFSET_BITS     = 8;
   localparam int VA_W            = 16;
   localparam int PAGE_W          = 4;
   localparam int FRAME_W         = 3;
   localparam int PA_W            = 11;
   localparam int ENTRY_W         = 2;
   localparam int STATUS_W        = 3;
   localparam int RECENCY_DEPTH   = 16;
   localparam logic [VA_W-1:0] PAGE_MASK   = 16'h0F00;
   localparam logic [VA_W-1:0] OFFSET_MASK = 16'h00FF;

   typedef enum logic [STATUS_W-1:0] {
      ST_TLB_HIT   = 3'd0,
      ST_TABLE_HIT = 3'd1,
      ST_FAULT     = 3'd2,
      ST_EVICT     = 3'd3,
      ST_ADDR_ERR  = 3'd4
   } status_type;
endpackage

/* rtl/tlbpt_recency.sv */
`timescale 1ns / 1ps
// LRU list, oldest first. One operation per cycle: remove a page, or
// touch it (remove and append at the tail).
module tlbpt_recency (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        op_valid,
   input  logic                        op_touch,
   input  logic [tlbpt_pkg::PAGE_W-1:0] op_page,
   output logic [tlbpt_pkg::PAGE_W-1:0] oldest,
   output logic                        empty
);
   import tlbpt_pkg::*;

   logic [PAGE_W-1:0] order_ff [RECENCY_DEPTH];
   logic [PAGE_W-1:0] order_in [RECENCY_DEPTH];
   logic [4:0]        count_ff, count_in;
   logic [RECENCY_DEPTH-1:0] match;
   logic [RECENCY_DEPTH-1:0] after;
   logic              found;
   logic [4:0]        cnt_rm;

   always_comb begin
      for (int i = 0; i < RECENCY_DEPTH; i++)
         match[i] = (5'(i) < count_ff) && (order_ff[i] == op_page);
      // after[i]: an earlier or equal slot matched (first match only counts)
      after[0] = match[0];
      for (int i = 1; i < RECENCY_DEPTH; i++)
         after[i] = after[i-1] | match[i];
      found  = after[RECENCY_DEPTH-1];
      cnt_rm = found ? count_ff - 5'd1 : count_ff;
      for (int i = 0; i < RECENCY_DEPTH; i++) begin
         if (after[i] && i + 1 < RECENCY_DEPTH)
            order_in[i] = order_ff[(i + 1) % RECENCY_DEPTH];
         else
            order_in[i] = order_ff[i];
      end
      count_in = cnt_rm;
      if (op_touch && cnt_rm < 5'(RECENCY_DEPTH)) begin
         order_in[cnt_rm[3:0]] = op_page;
         count_in = cnt_rm + 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (op_valid) begin
         count_ff <= count_in;
      end
      if (op_valid) begin
         for (int i = 0; i < RECENCY_DEPTH; i++)
            order_ff[i] <= order_in[i];
      end
   end

   assign oldest = order_ff[0];
   assign empty  = (count_ff == '0);

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 5'(RECENCY_DEPTH)) else $error("recency count overflow");
   a_touch_nonempty: assert property (@(posedge clock) disable iff (reset)
      op_valid && op_touch |=> !empty) else $error("touch left list empty");
   a_remove_shrinks: assert property (@(posedge clock) disable iff (reset)
      op_valid && !op_touch && found |=> count_ff == $past(count_ff) - 5'd1)
      else $error("remove did not shrink list");
`endif
endmodule

/* rtl/tlb_page_table_translator.sv */
`timescale 1ns / 1ps
// The sequencer walks lookup, eviction, recency update and TLB write in turn, then holds the
// response until it is not stalled; an address error goes straight to the response. It accepts
// the next request only back in idle.
// Reset (synchronous, active high) clears residency, TLB valid bits,
// replace pointer, frame count, recency list and sets address_limit to 65535.
module tlb_page_table_translator
   import tlbpt_pkg::*;
#(
   parameter int PAGE_COUNT  = PAGE_COUNT_DEF,
   parameter int FRAME_COUNT = FRAME_COUNT_DEF,
   parameter int TLB_DEPTH   = TLB_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [tlbpt_pkg::VA_W-1:0]    req_virtual_address,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [tlbpt_pkg::STATUS_W-1:0] rsp_status,
   output logic [tlbpt_pkg::PAGE_W-1:0]  rsp_page,
   output logic [tlbpt_pkg::FRAME_W-1:0] rsp_frame,
   output logic [tlbpt_pkg::PA_W-1:0]    rsp_physical_address,
   output logic [tlbpt_pkg::ENTRY_W-1:0] rsp_tlb_entry,
   output logic [tlbpt_pkg::PAGE_W-1:0]  rsp_evicted_page,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [tlbpt_pkg::VA_W-1:0]    csr_data
);
   localparam int TW = (TLB_DEPTH > 1) ? $clog2(TLB_DEPTH) : 1;
   localparam int FCW = $clog2(FRAME_COUNT + 1);

   typedef enum logic [2:0] {S_IDLE, S_LOOKUP, S_EVICT, S_UPDATE, S_RESP} state_type;

   state_type         state_ff;
   logic [VA_W-1:0]   limit_ff;
   logic [VA_W-1:0]   addr_ff;
   logic [PAGE_W-1:0] page_ff;
   logic [FRAME_W-1:0] frame_ff;
   logic [PAGE_W-1:0] evict_ff;
   logic [STATUS_W-1:0] status_ff;
   logic [ENTRY_W-1:0] entry_ff;
   logic              rewrite_ff;

   logic [FRAME_W-1:0] map_ff [PAGE_COUNT];
   logic [PAGE_COUNT-1:0] resident_ff;
   logic [PAGE_W-1:0] tag_ff [TLB_DEPTH];
   logic [FRAME_W-1:0] tfr_ff [TLB_DEPTH];
   logic [TLB_DEPTH-1:0] tvalid_ff;
   logic [TW-1:0]     rptr_ff;
   logic [FCW-1:0]    used_ff;

   logic              rec_valid, rec_touch;
   logic [PAGE_W-1:0] rec_page, rec_oldest;
   logic              rec_empty;

   // shared TLB search unit, keyed by a selectable page
   logic [PAGE_W-1:0] key;
   logic              t_hit;
   logic [TW-1:0]     t_idx;
   logic              t_free;
   logic [TW-1:0]     t_free_idx;

   logic [PAGE_W-1:0] req_page;
   assign req_page = PAGE_W'((req_virtual_address & PAGE_MASK) >> OFFSET_BITS);

   always_comb begin
      t_hit = 1'b0;
      t_idx = '0;
      t_free = 1'b0;
      t_free_idx = '0;
      for (int i = TLB_DEPTH - 1; i >= 0; i--) begin
         if (tvalid_ff[i] && tag_ff[i] == key) begin
            t_hit = 1'b1;
            t_idx = TW'(i);
         end
         if (!tvalid_ff[i]) begin
            t_free = 1'b1;
            t_free_idx = TW'(i);
         end
      end
   end

   assign key = (state_ff == S_EVICT) ? evict_ff : page_ff;

   tlbpt_recency u_recency (
      .clock  (clock),
      .reset  (reset),
      .op_valid(rec_valid),
      .op_touch(rec_touch),
      .op_page(rec_page),
      .oldest (rec_oldest),
      .empty  (rec_empty)
   );

   always_comb begin
      rec_valid = 1'b0;
      rec_touch = 1'b0;
      rec_page  = page_ff;
      if (state_ff == S_EVICT) begin
         rec_valid = 1'b1;
         rec_page  = evict_ff;
      end else if (state_ff == S_UPDATE) begin
         rec_valid = 1'b1;
         rec_touch = 1'b1;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         limit_ff    <= '1;
         resident_ff <= '0;
         tvalid_ff   <= '0;
         rptr_ff     <= '0;
         used_ff     <= '0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (csr_valid)
                  limit_ff <= csr_data;
               if (req_valid) begin
                  addr_ff  <= req_virtual_address;
                  page_ff  <= req_page;
                  evict_ff <= '0;
                  frame_ff <= '0;
                  entry_ff <= '0;
                  rewrite_ff <= 1'b0;
                  if (req_virtual_address > limit_ff ||
                      32'(req_page) >= 32'(PAGE_COUNT)) begin
                     status_ff <= ST_ADDR_ERR;
                     state_ff  <= S_RESP;
                  end else begin
                     state_ff <= S_LOOKUP;
                  end
               end
            end
            S_LOOKUP: begin
               if (t_hit) begin
                  status_ff <= ST_TLB_HIT;
                  frame_ff  <= tfr_ff[t_idx];
                  entry_ff  <= ENTRY_W'(t_idx);
                  state_ff  <= S_UPDATE;
               end else if (resident_ff[page_ff]) begin
                  status_ff <= ST_TABLE_HIT;
                  frame_ff  <= map_ff[page_ff];
                  state_ff  <= S_UPDATE;
               end else if (32'(used_ff) < 32'(FRAME_COUNT)) begin
                  status_ff <= ST_FAULT;
                  frame_ff  <= FRAME_W'(used_ff);
                  used_ff   <= used_ff + FCW'(1);
                  map_ff[page_ff] <= FRAME_W'(used_ff);
                  resident_ff[page_ff] <= 1'b1;
                  state_ff  <= S_UPDATE;
               end else begin
                  status_ff <= ST_EVICT;
                  evict_ff  <= rec_empty ? '0 : rec_oldest;
                  state_ff  <= S_EVICT;
               end
            end
            S_EVICT: begin
               // drop victim from table and list, hand its frame over
               frame_ff <= map_ff[evict_ff];
               map_ff[page_ff] <= map_ff[evict_ff];
               resident_ff[evict_ff] <= 1'b0;
               resident_ff[page_ff]  <= 1'b1;
               rewrite_ff <= t_hit;
               if (t_hit) begin
                  tag_ff[t_idx] <= page_ff;
                  tfr_ff[t_idx] <= map_ff[evict_ff];
                  entry_ff <= ENTRY_W'(t_idx);
               end
               state_ff <= S_UPDATE;
            end
            S_UPDATE: begin
               if (status_ff != ST_TLB_HIT && !rewrite_ff) begin
                  if (t_free) begin
                     tag_ff[t_free_idx] <= page_ff;
                     tfr_ff[t_free_idx] <= frame_ff;
                     tvalid_ff[t_free_idx] <= 1'b1;
                     entry_ff <= ENTRY_W'(t_free_idx);
                  end else begin
                     tag_ff[rptr_ff] <= page_ff;
                     tfr_ff[rptr_ff] <= frame_ff;
                     entry_ff <= ENTRY_W'(rptr_ff);
                     rptr_ff <= (32'(rptr_ff) == TLB_DEPTH - 1) ? '0 : rptr_ff + TW'(1);
                  end
               end
               state_ff <= S_RESP;
            end
            S_RESP: begin
               if (!rsp_stall)
                  state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // address errors report a zero physical address
   assign rsp_status = status_ff;
   assign rsp_page   = page_ff;
   assign rsp_frame  = frame_ff;
   assign rsp_physical_address = (status_ff == ST_ADDR_ERR) ? '0 :
                                 {frame_ff, addr_ff[OFFSET_BITS-1:0]};
   assign rsp_tlb_entry   = entry_ff;
   assign rsp_evicted_page = evict_ff;

`ifndef SYNTHESIS
   a_err_no_state: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE && req_valid && !req_stall && req_virtual_address > limit_ff
      |=> $stable(resident_ff) && $stable(tvalid_ff)) else $error("error changed state");
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      32'(used_ff) <= FRAME_COUNT) else $error("frame count overflow");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_frame))
      else $error("response dropped");
`endif
endmodule

/* dv/tlb_translation_checker.sv */
`timescale 1ns / 1ps
module tlb_translation_checker
   import tlbpt_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic [VA_W-1:0]     req_virtual_address,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic [STATUS_W-1:0] rsp_status,
   input  logic [PAGE_W-1:0]   rsp_page,
   input  logic [FRAME_W-1:0]  rsp_frame,
   input  logic [PA_W-1:0]     rsp_physical_address,
   input  logic [ENTRY_W-1:0]  rsp_tlb_entry,
   input  logic [PAGE_W-1:0]   rsp_evicted_page,
   input  logic                csr_valid,
   input  logic                csr_ready,
   input  logic [VA_W-1:0]     csr_data,
   output int                  error_count,
   output int                  pending_count,
   output int                  evict_count
);
   localparam int PAGES  = PAGE_COUNT_DEF;
   localparam int FRAMES = FRAME_COUNT_DEF;
   localparam int TLBS   = TLB_DEPTH_DEF;

   typedef struct {
      status_type         status;
      logic [PAGE_W-1:0]  page;
      logic [FRAME_W-1:0] frame;
      logic [PA_W-1:0]    paddr;
      logic [ENTRY_W-1:0] entry;
      logic [PAGE_W-1:0]  evicted;
   } translation_type;

   translation_type    translation_q[$];
   logic [VA_W-1:0]    limit_reg;
   logic [FRAME_W-1:0] frame_of[PAGES];
   logic               resident[PAGES];
   logic [PAGE_W-1:0]  tag[TLBS];
   logic [FRAME_W-1:0] tlb_frame[TLBS];
   logic               tlb_valid[TLBS];
   int                 fifo_ptr;
   int                 frames_used;
   logic [PAGE_W-1:0]  lru_q[$];

   assign pending_count = translation_q.size();

   task automatic report(input string what, input int got, input int want);
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   function automatic void lru_drop(input logic [PAGE_W-1:0] pg);
      for (int i = 0; i < lru_q.size(); i++) begin
         if (lru_q[i] == pg) begin
            lru_q.delete(i);
            return;
         end
      end
   endfunction

   function automatic void lru_touch(input logic [PAGE_W-1:0] pg);
      lru_drop(pg);
      lru_q.insert(lru_q.size(), pg);
   endfunction

   function automatic int tlb_lookup(input logic [PAGE_W-1:0] pg);
      for (int i = 0; i < TLBS; i++)
         if (tlb_valid[i] && tag[i] == pg) return i;
      return -1;
   endfunction

   function automatic int tlb_fill(input logic [PAGE_W-1:0] pg, input logic [FRAME_W-1:0] fr);
      int e;
      for (int i = 0; i < TLBS; i++) begin
         if (!tlb_valid[i]) begin
            tag[i] = pg;
            tlb_frame[i] = fr;
            tlb_valid[i] = 1'b1;
            return i;
         end
      end
      e = fifo_ptr;
      tag[e] = pg;
      tlb_frame[e] = fr;
      fifo_ptr = (e + 1) % TLBS;
      return e;
   endfunction

   function automatic translation_type translate(input logic [VA_W-1:0] va);
      translation_type t;
      logic [PAGE_W-1:0] pg;
      int hit;
      pg = PAGE_W'((va & PAGE_MASK) >> OFFSET_BITS);
      t.page = pg;
      t.frame = '0;
      t.paddr = '0;
      t.entry = '0;
      t.evicted = '0;
      if (va > limit_reg || int'(pg) >= PAGES) begin
         t.status = ST_ADDR_ERR;
         return t;
      end
      hit = tlb_lookup(pg);
      if (hit >= 0) begin
         t.status = ST_TLB_HIT;
         t.entry = ENTRY_W'(hit);
         t.frame = tlb_frame[hit];
         lru_touch(pg);
      end else if (resident[pg]) begin
         t.status = ST_TABLE_HIT;
         t.frame = frame_of[pg];
         lru_touch(pg);
         t.entry = ENTRY_W'(tlb_fill(pg, t.frame));
      end else if (frames_used < FRAMES) begin
         t.status = ST_FAULT;
         t.frame = FRAME_W'(frames_used);
         frames_used++;
         frame_of[pg] = t.frame;
         resident[pg] = 1'b1;
         lru_touch(pg);
         t.entry = ENTRY_W'(tlb_fill(pg, t.frame));
      end else begin
         t.status = ST_EVICT;
         t.evicted = lru_q[0];
         t.frame = frame_of[t.evicted];
         resident[t.evicted] = 1'b0;
         lru_drop(t.evicted);
         frame_of[pg] = t.frame;
         resident[pg] = 1'b1;
         lru_touch(pg);
         // rewrite the victim's TLB entry in place, pointer stays
         hit = tlb_lookup(t.evicted);
         if (hit >= 0) begin
            tag[hit] = pg;
            tlb_frame[hit] = t.frame;
            t.entry = ENTRY_W'(hit);
         end else begin
            t.entry = ENTRY_W'(tlb_fill(pg, t.frame));
         end
      end
      t.paddr = {t.frame, va[OFFSET_BITS-1:0]};
      return t;
   endfunction

   initial begin
      error_count = 0;
      evict_count = 0;
   end

   always @(posedge clock) begin
      translation_type want;
      if (reset) begin
         translation_q.delete();
         lru_q.delete();
         limit_reg = '1;
         fifo_ptr = 0;
         frames_used = 0;
         for (int i = 0; i < PAGES; i++) resident[i] = 1'b0;
         for (int i = 0; i < TLBS; i++) tlb_valid[i] = 1'b0;
      end else begin
         if (csr_valid && csr_ready) limit_reg = csr_data;
         if (req_valid && !req_stall) begin
            want = translate(req_virtual_address);
            if (want.status == ST_EVICT) evict_count++;
            translation_q.insert(translation_q.size(), want);
         end
         if (rsp_valid && !rsp_stall) begin
            if (translation_q.size() == 0) begin
               report("unexpected transaction, status", rsp_status, -1);
            end else begin
               want = translation_q.pop_front();
               if (rsp_status != want.status) report("status", rsp_status, want.status);
               if (rsp_page != want.page) report("page", rsp_page, want.page);
               if (rsp_frame != want.frame) report("frame", rsp_frame, want.frame);
               if (rsp_physical_address != want.paddr)
                  report("physical_address", rsp_physical_address, want.paddr);
               if (rsp_tlb_entry != want.entry) report("tlb_entry", rsp_tlb_entry, want.entry);
               if (rsp_evicted_page != want.evicted)
                  report("evicted_page", rsp_evicted_page, want.evicted);
            end
         end
      end
   end
endmodule

/* dv/tlb_page_table_translator_tb.sv */
`timescale 1ns / 1ps
module tlb_page_table_translator_tb;
   import tlbpt_pkg::*;

   localparam int CYCLE_LIMIT = 600000;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [VA_W-1:0]     req_virtual_address = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [PAGE_W-1:0]   rsp_page;
   logic [FRAME_W-1:0]  rsp_frame;
   logic [PA_W-1:0]     rsp_physical_address;
   logic [ENTRY_W-1:0]  rsp_tlb_entry;
   logic [PAGE_W-1:0]   rsp_evicted_page;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [VA_W-1:0]     csr_data = '0;
   int                  error_count, pending_count, evict_count;
   int                  cycle_count = 0;
   int                  sent_count = 0;
   int                  limit_writes = 0;
   logic [VA_W-1:0]     cur_limit = '1;
   int                  stall_mode = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   tlb_page_table_translator dut (.*);

   tlb_translation_checker u_checker (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL tlb_page_table_translator");
         $finish;
      end
   end

   // receiver: switch between no stall, light stalls and two heavy-stall modes
   always @(posedge clock) begin
      if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= ($urandom_range(0, 15) < 12);
      endcase
   end

   task automatic send_addr(input logic [VA_W-1:0] va);
      req_valid <= 1'b1;
      req_virtual_address <= va;
      do @(posedge clock); while (req_stall);
      sent_count++;
   endtask

   task automatic go_idle(input int gap);
      req_valid <= 1'b0;
      repeat (gap) @(posedge clock);
   endtask

   task automatic write_limit(input logic [VA_W-1:0] v);
      go_idle(0);
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cur_limit = v;
      limit_writes++;
   endtask

   function automatic logic [VA_W-1:0] pick_addr(input int ws_base, input int ws_size);
      int r;
      logic [VA_W-1:0] va;
      r = $urandom_range(0, 99);
      va = VA_W'($urandom);
      if (r < 70) begin
         // stay in a small working set of pages to exercise hits and LRU
         va[11:8] = 4'((ws_base + int'($urandom_range(0, ws_size - 1))) % 16);
         if ($urandom_range(0, 1)) va[15:12] = 4'h0;
      end else if (r < 85) begin
         va = VA_W'(int'(cur_limit) + int'($urandom_range(0, 3)) - 2);
      end
      return va;
   endfunction

   task automatic random_phase(input int count);
      int ws_base, ws_size, burst;
      ws_base = $urandom_range(0, 15);
      ws_size = $urandom_range(3, 12);
      while (count > 0) begin
         burst = $urandom_range(1, 20);
         while (burst > 0 && count > 0) begin
            if ($urandom_range(0, 63) == 0) begin
               ws_base = $urandom_range(0, 15);
               ws_size = $urandom_range(3, 12);
            end
            send_addr(pick_addr(ws_base, ws_size));
            burst--;
            count--;
         end
         if ($urandom_range(0, 2) != 0) go_idle($urandom_range(1, 8));
      end
   endtask

   initial begin
      int dir_pages[$];
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fill all frames, overflow the TLB, then force evictions
      dir_pages = '{0, 1, 2, 3, 4, 5, 6, 7, 0, 8, 9, 4, 5, 10, 15};
      foreach (dir_pages[i]) send_addr({4'h0, 4'(dir_pages[i]), 8'($urandom)});
      send_addr(16'h0000);
      send_addr(16'hFFFF);
      send_addr(16'hF0FF);
      write_limit(16'h1234);
      send_addr(16'h1235);
      send_addr(16'h1234);
      send_addr(16'h1233);
      write_limit(16'h0000);
      send_addr(16'h0000);
      send_addr(16'h0001);
      write_limit(16'hFFFF);

      random_phase(450);
      write_limit(VA_W'($urandom_range(16'h0100, 16'hFFFE)));
      random_phase(350);
      write_limit(16'h0000);
      random_phase(80);
      write_limit(16'h07FF);
      random_phase(350);
      write_limit(16'hFFFF);
      random_phase(550);

      go_idle(0);
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("sent %0d addresses across %0d limit settings, %0d evictions predicted",
               sent_count, limit_writes + 1, evict_count);
      if (error_count == 0) begin
         $display("PASS tlb_page_table_translator");
      end else begin
         $display("FAIL tlb_page_table_translator");
      end
      $finish;
   end
endmodule

/* filelist.f */
rtl/tlbpt_pkg.sv
rtl/tlbpt_recency.sv
rtl/tlb_page_table_translator.sv
dv/tlb_translation_checker.sv
dv/tlb_page_table_translator_tb.sv
